// File: design/tdf_pkg.sv
// Package for the trial division factorizer: widths, limits and the
// request/response structs between the controller and the serial divider.
// No dependencies.
package tdf_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int EXP_WIDTH   = 5;
	localparam int MAX_RESULTS = 9;

	localparam logic [EXP_WIDTH-1:0] EXP_MAX = {EXP_WIDTH{1'b1}};

	// divider bit counter
	localparam int DIV_CNT_W = $clog2(VALUE_WIDTH);
	localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);

	// results-per-run counter
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam logic [RES_CNT_W-1:0] RES_CNT_LAST = RES_CNT_W'(MAX_RESULTS - 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [EXP_WIDTH-1:0]   exp_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quot;
		value_t rem;
	} div_rsp_t;

endpackage

// File: design/tdf_if.sv
// Valid/ready channel interfaces for the factorizer: input values and
// (prime, exponent, last) results. Depends on tdf_pkg.
interface tdf_value_if import tdf_pkg::*;;
	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface tdf_factor_if import tdf_pkg::*;;
	logic   valid;
	logic   ready;
	value_t prime_factor;
	exp_t   exponent;
	logic   last_factor;

	modport source (output valid, output prime_factor, output exponent,
		output last_factor, input ready);
	modport sink   (input valid, input prime_factor, input exponent,
		input last_factor, output ready);
endinterface

// File: design/trial_division_factorizer_core.sv
// Per trial divisor: launch (ST_START), division in tdf_div at one quotient
// bit per cycle (ST_DIV), then evaluate (ST_EVAL).
// An input takes one such pass per divisor tried and per division out;
// one input is worked on at a time.
// Results leave through a one-entry output register.
// arst_n clears the controller and output valid; no clearing pass needed.
module trial_division_factorizer_core import tdf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tdf_value_if.sink    value_ch,
	tdf_factor_if.source factor_ch
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_EVAL  = 4'b1000
	} state_t;

	state_t                 st_q, st_d;
	value_t                 rem_q, rem_d;
	value_t                 d_q, d_d;
	exp_t                   cnt_q, cnt_d;
	logic [RES_CNT_W-1:0]   k_q, k_d;

	logic                   out_valid_q;
	value_t                 out_prime_q;
	exp_t                   out_exp_q;
	logic                   out_last_q;

	logic                   load;
	value_t                 load_prime;
	exp_t                   load_exp;
	logic                   load_last;
	logic                   emit_ok;

	div_req_t               div_req;
	div_rsp_t               div_rsp;

	tdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.start    = (st_q == ST_START);
	assign div_req.dividend = rem_q;
	assign div_req.divisor  = d_q;

	assign value_ch.ready = (st_q == ST_IDLE);
	assign emit_ok        = !out_valid_q || factor_ch.ready;

	always_comb begin
		st_d       = st_q;
		rem_d      = rem_q;
		d_d        = d_q;
		cnt_d      = cnt_q;
		k_d        = k_q;
		load       = 1'b0;
		load_prime = d_q;
		load_exp   = cnt_q;
		load_last  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (value_ch.valid) begin
					rem_d = value_ch.value;
					d_d   = VALUE_WIDTH'(2);
					cnt_d = '0;
					k_d   = '0;
					if (value_ch.value > VALUE_WIDTH'(1))
						st_d = ST_START;
				end
			end
			ST_START: st_d = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done)
					st_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (cnt_q != '0) begin
					// dividing out the current prime
					if (div_rsp.rem == '0) begin
						rem_d = div_rsp.quot;
						cnt_d = (cnt_q == EXP_MAX) ? cnt_q : cnt_q + 1'b1;
						st_d  = ST_START;
					end else begin
						// a reduced remainder of one means no more factors follow
						load_last = (rem_q == VALUE_WIDTH'(1)) || (k_q == RES_CNT_LAST);
						if (emit_ok) begin
							load  = 1'b1;
							k_d   = k_q + 1'b1;
							d_d   = d_q + 1'b1;
							cnt_d = '0;
							st_d  = load_last ? ST_IDLE : ST_START;
						end
					end
				end else if (d_q > div_rsp.quot) begin
					// divisor squared exceeds remainder: what is left is prime
					if (rem_q > VALUE_WIDTH'(1)) begin
						load_prime = rem_q;
						load_exp   = EXP_WIDTH'(1);
						load_last  = 1'b1;
						if (emit_ok) begin
							load = 1'b1;
							k_d  = k_q + 1'b1;
							st_d = ST_IDLE;
						end
					end else begin
						st_d = ST_IDLE;
					end
				end else if (div_rsp.rem == '0) begin
					rem_d = div_rsp.quot;
					cnt_d = EXP_WIDTH'(1);
					st_d  = ST_START;
				end else begin
					d_d  = d_q + 1'b1;
					st_d = ST_START;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			k_q   <= k_d;
			cnt_q <= cnt_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (factor_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		d_q   <= d_d;
		if (load) begin
			out_prime_q <= load_prime;
			out_exp_q   <= load_exp;
			out_last_q  <= load_last;
		end
	end

	assign factor_ch.valid        = out_valid_q;
	assign factor_ch.prime_factor = out_prime_q;
	assign factor_ch.exponent     = out_exp_q;
	assign factor_ch.last_factor  = out_last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> emit_ok)
		else $error("result loaded over an untaken one");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && load_last |=> st_q == ST_IDLE)
		else $error("run continued after last factor");

	a_res_cap: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("too many results in one run");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> st_q == ST_DIV)
		else $error("divider finished outside divide state");

endmodule

// File: design/tdf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tdf_pkg.
module tdf_div import tdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	value_t                 pr_q;
	value_t                 dvd_q;
	value_t                 dsr_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH+1:0] diff;
	logic                   fits;

	always_comb begin
		trial = {pr_q, dvd_q[VALUE_WIDTH-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		fits  = ~diff[VALUE_WIDTH+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_LAST)
				busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// dividend register shifts out dividend bits and shifts in quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			pr_q  <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			pr_q  <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign rsp.done = busy_q && (cnt_q == DIV_CNT_LAST);
	assign rsp.quot = dvd_q;
	assign rsp.rem  = pr_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !rsp.done |-> !req.start)
		else $error("divider restarted mid-operation");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && !req.start |=> !busy_q)
		else $error("divider still busy after done");

	a_partial_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pr_q < dsr_q)
		else $error("partial remainder not below divisor");

endmodule
